// ===== rtl/glyph_and_pixel_write_formatter_defines.svh =====
// Assertion macros shared by the glyph and pixel write formatter.
`ifndef GLYPH_AND_PIXEL_WRITE_FORMATTER_DEFINES_SVH
`define GLYPH_AND_PIXEL_WRITE_FORMATTER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define GPWF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define GPWF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpwf_pkg.sv =====
// Package with shared types, constants and pixel helpers of the write formatter.
`timescale 1ns / 1ps
`default_nettype none

package gpwf_pkg;

   // Glyph geometry fixed by the font format
   localparam int GLYPH_WIDTH = 8;
   localparam int LANE_IDX_W  = $clog2(GLYPH_WIDTH);

   // Field widths
   localparam int ADDR_W  = 28;
   localparam int COLOR_W = 32;
   localparam int POS_W   = 12;
   localparam int DIM_W   = 13;
   localparam int PITCH_W = 16;
   localparam int BPP_W   = 8;
   localparam int NB_W    = 3;
   localparam int CSR_W   = 16;

   // Register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_LINE_PITCH    = 2'd2;
   localparam logic [1:0] CSR_BITS_PER_PIX  = 2'd3;

   // Request operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_GLYPH = 1'b1;

   // Supported depths and their byte counts
   localparam logic [BPP_W-1:0] BPP_16 = 8'd16;
   localparam logic [BPP_W-1:0] BPP_24 = 8'd24;
   localparam logic [BPP_W-1:0] BPP_32 = 8'd32;
   localparam logic [NB_W-1:0]  NB_NONE = 3'd0;
   localparam logic [NB_W-1:0]  NB_16   = 3'd2;
   localparam logic [NB_W-1:0]  NB_24   = 3'd3;
   localparam logic [NB_W-1:0]  NB_32   = 3'd4;

   // Per-request data handed to every lane
   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [POS_W-1:0]   pos_x;
      logic [NB_W-1:0]    nbytes;
      logic [COLOR_W-1:0] fg_px;
      logic [COLOR_W-1:0] bg_px;
   } lane_in_type;

   // Byte count for a depth, NB_NONE when the depth writes nothing
   function automatic logic [NB_W-1:0] bytes_for_depth(input logic [BPP_W-1:0] bpp);
      logic [NB_W-1:0] nb;
      nb = NB_NONE;
      priority if (bpp == BPP_32) nb = NB_32;
      else if (bpp == BPP_24) nb = NB_24;
      else if (bpp == BPP_16) nb = NB_16;
      else nb = NB_NONE;
      return nb;
   endfunction

   // Format a 0x00RRGGBB color for the given depth
   function automatic logic [COLOR_W-1:0] format_color(input logic [COLOR_W-1:0] color,
                                                       input logic [BPP_W-1:0]   bpp);
      logic [COLOR_W-1:0] px;
      px = '0;
      priority if (bpp == BPP_32) px = color;
      else if (bpp == BPP_24) px = {8'h00, color[23:0]};
      else px = {16'h0000, color[23:19], color[15:10], color[7:3]};
      return px;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gpwf_lane.sv =====
// One pixel lane: column address and foreground or background selection.
`timescale 1ns / 1ps
`default_nettype none

module gpwf_lane
   import gpwf_pkg::*;
#(
   parameter int LANE = 0
) (
   input  lane_in_type        lane_in,
   input  logic               pix_on,
   output logic [ADDR_W-1:0]  lane_addr,
   output logic [COLOR_W-1:0] lane_data
);

   localparam logic [DIM_W-1:0] LaneOffset = DIM_W'(LANE);

   logic [DIM_W-1:0]   col_x;
   logic [DIM_W+1:0]   col_off;

   // Column of this lane, scaled by the pixel size
   always_comb begin
      col_x = {1'b0, lane_in.pos_x} + LaneOffset;
      unique case (lane_in.nbytes)
         NB_16:   col_off = {1'b0, col_x, 1'b0};
         NB_24:   col_off = {1'b0, col_x, 1'b0} + {2'b00, col_x};
         default: col_off = {col_x, 2'b00};
      endcase
   end

   assign lane_addr = lane_in.base + ADDR_W'(col_off);
   assign lane_data = pix_on ? lane_in.fg_px : lane_in.bg_px;

endmodule

`default_nettype wire

// ===== rtl/glyph_and_pixel_write_formatter.sv =====
// Top level: request decode, clip, line address, pixel lanes and write bank.
//
//  channel | direction | handshake             | carries
//  req_    | in        | req_valid / req_ready | one pixel or one glyph row request
//  rsp_    | out       | rsp_valid / rsp_ready | one framebuffer write
//  csr_    | in        | csr_write_en          | screen size, pitch and depth
//
// The first write of a request appears at the result port once the request has
// passed the decode stage, the line stage and the write bank.
// A glyph row gives eight writes, a pixel one; the single result port drains
// the eight-lane bank one write a cycle while rsp_ready is high.
// Requests enter every cycle while the pipeline ahead has room; a stalled result
// port holds the bank, then the line stage, then the decode stage.
// Reset zeroes valid flags, bank index and CSRs, not data; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_and_pixel_write_formatter_defines.svh"

module glyph_and_pixel_write_formatter
   import gpwf_pkg::*;
#(
   parameter int MAX_DIM      = 4096,
   parameter int GLYPH_HEIGHT = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [POS_W-1:0]   req_pos_x,
   input  logic [POS_W-1:0]   req_pos_y,
   input  logic [3:0]         req_glyph_row,
   input  logic [7:0]         req_glyph_bits,
   input  logic [COLOR_W-1:0] req_fg_color,
   input  logic [COLOR_W-1:0] req_back_color,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ADDR_W-1:0]  rsp_byte_address,
   output logic [COLOR_W-1:0] rsp_pixel_data,
   output logic [NB_W-1:0]    rsp_byte_count,
   output logic               rsp_last,
   // configuration
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_write_data
);

   localparam int DimCapInt = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
   localparam logic [DIM_W-1:0] DimCap = DIM_W'(DimCapInt);
   localparam logic [5:0] GlyphHeight = 6'(GLYPH_HEIGHT);
   localparam logic [LANE_IDX_W-1:0] LastLane = LANE_IDX_W'(GLYPH_WIDTH - 1);

   // Configuration registers
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [DIM_W-1:0]   dim_in;

   assign dim_in = (csr_write_data[DIM_W-1:0] > DimCap) ? DimCap : csr_write_data[DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         pitch_ff  <= '0;
         bpp_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= dim_in;
            CSR_SCREEN_HEIGHT: height_ff <= dim_in;
            CSR_LINE_PITCH:    pitch_ff  <= csr_write_data[PITCH_W-1:0];
            CSR_BITS_PER_PIX:  bpp_ff    <= csr_write_data[BPP_W-1:0];
         endcase
      end
   end

   // Pipeline control
   logic s1_valid_ff, s2_valid_ff, bank_valid_ff;
   logic s1_keep, s1_leave, s1_free;
   logic s2_move, s2_free;
   logic bank_done, bank_free;
   logic [LANE_IDX_W-1:0] bank_idx_ff, bank_end_ff;

   assign bank_done = bank_valid_ff && rsp_ready && (bank_idx_ff == bank_end_ff);
   assign bank_free = !bank_valid_ff || bank_done;
   assign s2_move   = s2_valid_ff && bank_free;
   assign s2_free   = !s2_valid_ff || s2_move;
   assign s1_leave  = s1_valid_ff && (!s1_keep || s2_free);
   assign s1_free   = !s1_valid_ff || s1_leave;
   assign req_ready = s1_free;

   // Decode stage: hold the request
   logic               s1_op_ff;
   logic [POS_W-1:0]   s1_x_ff, s1_y_ff;
   logic [3:0]         s1_row_ff;
   logic [7:0]         s1_bits_ff;
   logic [COLOR_W-1:0] s1_fg_ff, s1_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (s1_free) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_op_ff   <= req_op;
         s1_x_ff    <= req_pos_x;
         s1_y_ff    <= req_pos_y;
         s1_row_ff  <= req_glyph_row;
         s1_bits_ff <= req_glyph_bits;
         s1_fg_ff   <= req_fg_color;
         s1_bg_ff   <= req_back_color;
      end
   end

   // Decode stage: clip, line address and colour formatting
   logic [NB_W-1:0]    s1_nb;
   logic               s1_x_in, s1_y_in, s1_glyph_y_in, s1_row_in;
   logic [DIM_W-1:0]   s1_line;
   logic [DIM_W-1:0]   s1_glyph_limit;
   logic [DIM_W+PITCH_W-1:0] s1_prod;

   always_comb begin
      s1_nb          = bytes_for_depth(bpp_ff);
      s1_x_in        = {1'b0, s1_x_ff} < width_ff;
      s1_y_in        = {1'b0, s1_y_ff} < height_ff;
      s1_glyph_limit = height_ff - {{(DIM_W-6){1'b0}}, GlyphHeight};
      s1_glyph_y_in  = (height_ff < {{(DIM_W-6){1'b0}}, GlyphHeight})
                       || ({1'b0, s1_y_ff} < s1_glyph_limit);
      s1_row_in      = {2'b00, s1_row_ff} < GlyphHeight;
      if (s1_op_ff == OP_GLYPH) begin
         s1_keep = (s1_nb != NB_NONE) && s1_x_in && s1_glyph_y_in && s1_row_in;
         s1_line = {1'b0, s1_y_ff} + {{(DIM_W-4){1'b0}}, s1_row_ff};
      end else begin
         s1_keep = (s1_nb != NB_NONE) && s1_x_in && s1_y_in;
         s1_line = {1'b0, s1_y_ff};
      end
      s1_prod = s1_line * pitch_ff;
   end

   // Line stage: register the product and the formatted colours
   lane_in_type           s2_lane_ff;
   logic [7:0]            s2_bits_ff;
   logic [LANE_IDX_W-1:0] s2_end_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (s2_free) s2_valid_ff <= s1_valid_ff && s1_keep;
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff && s1_keep) begin
         s2_lane_ff.base   <= s1_prod[ADDR_W-1:0];
         s2_lane_ff.pos_x  <= s1_x_ff;
         s2_lane_ff.nbytes <= s1_nb;
         s2_lane_ff.fg_px  <= format_color(s1_fg_ff, bpp_ff);
         s2_lane_ff.bg_px  <= format_color(s1_bg_ff, bpp_ff);
         // a single pixel takes the foreground in lane zero
         s2_bits_ff        <= (s1_op_ff == OP_GLYPH) ? s1_bits_ff : 8'hFF;
         s2_end_ff         <= (s1_op_ff == OP_GLYPH) ? LastLane : '0;
      end
   end

   // Pixel lanes, leftmost pixel in lane zero
   logic [ADDR_W-1:0]  lane_addr [GLYPH_WIDTH];
   logic [COLOR_W-1:0] lane_data [GLYPH_WIDTH];

   for (genvar l = 0; l < GLYPH_WIDTH; l++) begin : g_lane
      gpwf_lane #(
         .LANE(l)
      ) u_lane (
         .lane_in  (s2_lane_ff),
         .pix_on   (s2_bits_ff[GLYPH_WIDTH-1-l]),
         .lane_addr(lane_addr[l]),
         .lane_data(lane_data[l])
      );
   end

   // Write bank: capture all lanes, then drain one write per cycle while rsp_ready is high
   logic [ADDR_W-1:0]  bank_addr_ff [GLYPH_WIDTH];
   logic [COLOR_W-1:0] bank_data_ff [GLYPH_WIDTH];
   logic [NB_W-1:0]    bank_nb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= 1'b0;
         bank_idx_ff   <= '0;
      end else if (bank_free) begin
         bank_valid_ff <= s2_valid_ff;
         bank_idx_ff   <= '0;
      end else if (rsp_ready) begin
         bank_idx_ff   <= bank_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         for (int l = 0; l < GLYPH_WIDTH; l++) begin
            bank_addr_ff[l] <= lane_addr[l];
            bank_data_ff[l] <= lane_data[l];
         end
         bank_nb_ff  <= s2_lane_ff.nbytes;
         bank_end_ff <= s2_end_ff;
      end
   end

   assign rsp_valid        = bank_valid_ff;
   assign rsp_byte_address = bank_addr_ff[bank_idx_ff];
   assign rsp_pixel_data   = bank_data_ff[bank_idx_ff];
   assign rsp_byte_count   = bank_nb_ff;
   assign rsp_last         = bank_idx_ff == bank_end_ff;

   // Conditions watched by the checks below
   logic rsp_mid_row, rsp_count_ok;

   assign rsp_mid_row  = rsp_valid && rsp_ready && !rsp_last;
   assign rsp_count_ok = (rsp_byte_count == NB_16) || (rsp_byte_count == NB_24)
                         || (rsp_byte_count == NB_32);

   // A kept request waiting at the bank enters as soon as the bank frees
   `GPWF_ASSERT_NEXT(a_bank_refill, clock, reset, s2_move, rsp_valid, "bank missed a refill")
   // A glyph row keeps writing until its last column
   `GPWF_ASSERT_NEXT(a_row_continues, clock, reset, rsp_mid_row, rsp_valid, "row ended early")
   // Every write carries a supported byte count
   `GPWF_ASSERT_SAME(a_byte_count, clock, reset, rsp_valid, rsp_count_ok, "bad byte count")

endmodule

`default_nettype wire
